/* hw/rtl/rwl_pkg.sv */
// Shared types and constants for the reader-writer lock unit.
`default_nettype none

package rwl_pkg;

    localparam int THREADS_DEF    = 16;
    localparam int DEPTH_BITS_DEF = 8;
    localparam int TID_W          = 4;
    localparam int FUNC_W         = 2;
    localparam int STATUS_W       = 3;
    localparam int COUNT_W        = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_LOCK   = 2'd0,
        FUNC_WR_UNLOCK = 2'd1,
        FUNC_RD_LOCK   = 2'd2,
        FUNC_RD_UNLOCK = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED              = 3'd0,
        ST_WAIT                 = 3'd1,
        ST_INVALID_UNLOCK       = 3'd2,
        ST_WRITE_UNDERFLOW      = 3'd3,
        ST_READ_DEPTH_UNDERFLOW = 3'd4,
        ST_READER_UNDERFLOW     = 3'd5,
        ST_READ_TO_WRITE        = 3'd6,
        ST_OVERFLOW             = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

`default_nettype wire

/* hw/rtl/rwl_ctrl.sv */
// Control state machine that sequences capture and evaluation of a request.
`default_nettype none

module rwl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    output logic               o_valid,
    output rwl_pkg::t_cmd      o_cmd
);

    rwl_pkg::t_state r_state;
    rwl_pkg::t_state n_state;
    logic            r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rwl_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == rwl_pkg::S_EXEC);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rwl_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = rwl_pkg::S_EXEC;
                end
            end
            rwl_pkg::S_EXEC: begin
                n_state = rwl_pkg::S_IDLE;
            end
            default: begin
                n_state = rwl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_busy     = 1'b1;
        unique case (r_state)
            rwl_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            rwl_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* hw/rtl/rwl_datapath.sv */
// Lock state registers and the per-request decision logic.
`default_nettype none

module rwl_datapath #(
    parameter int THREADS    = rwl_pkg::THREADS_DEF,
    parameter int DEPTH_BITS = rwl_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire rwl_pkg::t_cmd                  i_cmd,
    input  wire logic [rwl_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [rwl_pkg::TID_W-1:0]      i_thread_id,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_wdata,
    output logic [rwl_pkg::STATUS_W-1:0]        o_status,
    output logic [rwl_pkg::COUNT_W-1:0]         o_readers_now,
    output logic                                o_writer_held
);

    localparam int TW = $clog2(THREADS);

    // Captured request.
    rwl_pkg::t_func                  r_func;
    logic [rwl_pkg::TID_W-1:0]       r_tid;

    // Lock state.
    logic                            r_checks;
    logic                            r_owner_valid;
    logic [rwl_pkg::TID_W-1:0]       r_owner_thread;
    logic [rwl_pkg::COUNT_W-1:0]     r_write_depth;
    logic [rwl_pkg::COUNT_W-1:0]     r_reader_count;
    logic [THREADS-1:0]              r_writer_waiting;
    logic [DEPTH_BITS-1:0]           r_read_depth [THREADS];

    // Result registers.
    rwl_pkg::t_status                r_status;
    logic [rwl_pkg::COUNT_W-1:0]     r_readers_now;
    logic                            r_writer_held;

    logic                            n_owner_valid;
    logic [rwl_pkg::TID_W-1:0]       n_owner_thread;
    logic [rwl_pkg::COUNT_W-1:0]     n_write_depth;
    logic [rwl_pkg::COUNT_W-1:0]     n_reader_count;
    rwl_pkg::t_status                n_status;
    logic [DEPTH_BITS-1:0]           n_rd;
    logic                            rd_we;
    logic                            ww_set;
    logic                            ww_clr;

    logic [TW-1:0]                   idx;
    logic                            in_range;
    logic                            own;
    logic [DEPTH_BITS-1:0]           rd;
    logic                            rd_full;
    logic                            rd_zero;

    assign idx      = TW'(r_tid);
    assign in_range = (32'(r_tid) < 32'(THREADS));
    assign own      = r_owner_valid && (r_owner_thread == r_tid);
    assign rd       = r_read_depth[idx];
    assign rd_full  = (rd == {DEPTH_BITS{1'b1}});
    assign rd_zero  = (rd == '0);

    always_comb begin
        n_owner_valid  = r_owner_valid;
        n_owner_thread = r_owner_thread;
        n_write_depth  = r_write_depth;
        n_reader_count = r_reader_count;
        n_status       = rwl_pkg::ST_WAIT;
        n_rd           = rd;
        rd_we          = 1'b0;
        ww_set         = 1'b0;
        ww_clr         = 1'b0;
        if (!in_range) begin
            n_status = rwl_pkg::ST_INVALID_UNLOCK;
        end else begin
            case (r_func)
                rwl_pkg::FUNC_WR_LOCK: begin
                    if (own) begin
                        if (r_checks && !rd_zero) begin
                            n_status = rwl_pkg::ST_READ_TO_WRITE;
                        end else if (r_write_depth == {rwl_pkg::COUNT_W{1'b1}}) begin
                            n_status = rwl_pkg::ST_OVERFLOW;
                        end else begin
                            n_write_depth = r_write_depth + 1'b1;
                            n_status      = rwl_pkg::ST_GRANTED;
                        end
                    end else if (!r_owner_valid && (r_reader_count == '0)) begin
                        n_owner_valid  = 1'b1;
                        n_owner_thread = r_tid;
                        n_write_depth  = rwl_pkg::COUNT_W'(1);
                        ww_clr         = 1'b1;
                        n_status       = rwl_pkg::ST_GRANTED;
                    end else begin
                        // A refused writer raises its pending bit so new readers hold off.
                        ww_set   = 1'b1;
                        n_status = rwl_pkg::ST_WAIT;
                    end
                end
                rwl_pkg::FUNC_WR_UNLOCK: begin
                    if (!own) begin
                        n_status = rwl_pkg::ST_INVALID_UNLOCK;
                    end else if (r_write_depth == '0) begin
                        n_status = rwl_pkg::ST_WRITE_UNDERFLOW;
                    end else begin
                        n_write_depth = r_write_depth - 1'b1;
                        if (r_write_depth == rwl_pkg::COUNT_W'(1)) begin
                            n_owner_valid  = 1'b0;
                            n_owner_thread = '0;
                        end
                        n_status = rwl_pkg::ST_GRANTED;
                    end
                end
                rwl_pkg::FUNC_RD_LOCK: begin
                    if (own) begin
                        // The owning writer reads without counting as a reader.
                        if (r_checks && rd_full) begin
                            n_status = rwl_pkg::ST_OVERFLOW;
                        end else begin
                            if (r_checks) begin
                                n_rd  = rd + 1'b1;
                                rd_we = 1'b1;
                            end
                            n_status = rwl_pkg::ST_GRANTED;
                        end
                    end else if ((|r_writer_waiting) || r_owner_valid) begin
                        n_status = rwl_pkg::ST_WAIT;
                    end else if (r_reader_count == {rwl_pkg::COUNT_W{1'b1}}) begin
                        n_status = rwl_pkg::ST_OVERFLOW;
                    end else if (r_checks && rd_full) begin
                        n_status = rwl_pkg::ST_OVERFLOW;
                    end else begin
                        n_reader_count = r_reader_count + 1'b1;
                        if (r_checks) begin
                            n_rd  = rd + 1'b1;
                            rd_we = 1'b1;
                        end
                        n_status = rwl_pkg::ST_GRANTED;
                    end
                end
                rwl_pkg::FUNC_RD_UNLOCK: begin
                    if (r_checks && rd_zero) begin
                        n_status = rwl_pkg::ST_READ_DEPTH_UNDERFLOW;
                    end else if (!own && (r_owner_valid || (r_reader_count == '0))) begin
                        n_status = rwl_pkg::ST_READER_UNDERFLOW;
                    end else begin
                        if (!own) begin
                            n_reader_count = r_reader_count - 1'b1;
                        end
                        if (r_checks) begin
                            n_rd  = rd - 1'b1;
                            rd_we = 1'b1;
                        end
                        n_status = rwl_pkg::ST_GRANTED;
                    end
                end
                default: begin
                    n_status = rwl_pkg::ST_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= rwl_pkg::t_func'(i_func);
            r_tid  <= i_thread_id;
        end
        if (i_cmd.exec) begin
            r_status      <= n_status;
            r_readers_now <= n_reader_count;
            r_writer_held <= n_owner_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checks         <= 1'b1;
            r_owner_valid    <= 1'b0;
            r_owner_thread   <= '0;
            r_write_depth    <= '0;
            r_reader_count   <= '0;
            r_writer_waiting <= '0;
            for (int i = 0; i < THREADS; i++) begin
                r_read_depth[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_checks <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_owner_valid  <= n_owner_valid;
                r_owner_thread <= n_owner_thread;
                r_write_depth  <= n_write_depth;
                r_reader_count <= n_reader_count;
                if (ww_set) begin
                    r_writer_waiting[idx] <= 1'b1;
                end else if (ww_clr) begin
                    r_writer_waiting[idx] <= 1'b0;
                end
                if (rd_we) begin
                    r_read_depth[idx] <= n_rd;
                end
            end
        end
    end

    assign o_status      = r_status;
    assign o_readers_now = r_readers_now;
    assign o_writer_held = r_writer_held;

endmodule

`default_nettype wire

/* hw/rtl/reader_writer_lock_unit_core.sv */
// Top level of the reader-writer lock unit with writer preference.
//
//  Channel   | Handshake           | Signals
//  ----------+---------------------+---------------------------------------------
//  request   | start high, busy low| i_func, i_thread_id
//  result    | o_valid, one cycle  | o_status, o_readers_now, o_writer_held
//  config    | i_cfg_we            | i_cfg_wdata (debug checks enable)
//
// A request is captured in the idle state and evaluated against the lock state in the
// exec state, so busy is high for one cycle after each accepted request.
// The result appears in the cycle after evaluation, as a one-cycle o_valid pulse.
// The receiver cannot stall; results are never held back.
// Synchronous active-low reset clears the lock state and enables debug checks.
`default_nettype none

module reader_writer_lock_unit_core #(
    parameter int THREADS    = rwl_pkg::THREADS_DEF,
    parameter int DEPTH_BITS = rwl_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [rwl_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [rwl_pkg::TID_W-1:0]      i_thread_id,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_wdata,
    output logic                                o_valid,
    output logic [rwl_pkg::STATUS_W-1:0]        o_status,
    output logic [rwl_pkg::COUNT_W-1:0]         o_readers_now,
    output logic                                o_writer_held
);

    rwl_pkg::t_cmd cmd;

    rwl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    rwl_datapath #(
        .THREADS    (THREADS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_func),
        .i_thread_id   (i_thread_id),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_status      (o_status),
        .o_readers_now (o_readers_now),
        .o_writer_held (o_writer_held)
    );

endmodule

`default_nettype wire

/* hw/rtl/rwl_checker.sv */
// Port-level checks for the reader-writer lock unit, bound to the top level.
`default_nettype none

module rwl_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic                           o_valid,
    input  wire logic [rwl_pkg::COUNT_W-1:0]    o_readers_now,
    input  wire logic                           o_writer_held
);

    // Every accepted request is evaluated in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted request");

    // The result strobe follows the exec state, from the registered valid flag.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result missing two cycles after request");

    // One result per request, so strobes never come back to back.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // A held write lock excludes readers.
    a_writer_excludes_readers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_writer_held) |-> (o_readers_now == '0))
        else $error("writer holds the lock while readers are counted");

    // The unit is free again when a result is shown.
    a_idle_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy while a result is shown");

endmodule

bind reader_writer_lock_unit_core rwl_checker u_rwl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_readers_now (o_readers_now),
    .o_writer_held (o_writer_held)
);

`default_nettype wire

/* tb/reader_writer_lock_unit_core_test.sv */
// Self-checking testbench for the reader-writer lock unit: random and directed lock requests.
`timescale 1ns / 1ps

module reader_writer_lock_unit_core_test;

    // A correct run's length is set by the request count, the sender gaps in the random
    // phases and the quiet waits around each configuration write.
    localparam int LIMIT_CYCLES = 100_000;
    localparam int RANDOM_PER_PHASE = 190;

    typedef struct packed {
        rwl_pkg::t_func                func;
        logic [rwl_pkg::TID_W-1:0]     tid;
    } t_lock_req;

    typedef struct packed {
        rwl_pkg::t_status              status;
        logic [rwl_pkg::COUNT_W-1:0]   readers;
        logic                          held;
    } t_lock_answer;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [rwl_pkg::FUNC_W-1:0]     i_func = '0;
    logic [rwl_pkg::TID_W-1:0]      i_thread_id = '0;
    logic                           i_cfg_we = 1'b0;
    logic                           i_cfg_wdata = 1'b0;
    logic                           o_valid;
    logic [rwl_pkg::STATUS_W-1:0]   o_status;
    logic [rwl_pkg::COUNT_W-1:0]    o_readers_now;
    logic                           o_writer_held;

    t_lock_req    pending_requests[$];
    t_lock_answer expected_answers[$];
    int           idle_pct = 0;
    int           errors = 0;
    int           cycles = 0;
    bit           took = 1'b0;

    // Lock state as the testbench predicts it.
    logic                                lk_checks;
    logic                                lk_owner_valid;
    logic [rwl_pkg::TID_W-1:0]           lk_owner_tid;
    logic [rwl_pkg::COUNT_W-1:0]         lk_write_depth;
    logic [rwl_pkg::COUNT_W-1:0]         lk_reader_count;
    logic [rwl_pkg::THREADS_DEF-1:0]     lk_writers_waiting;
    logic [rwl_pkg::DEPTH_BITS_DEF-1:0]  lk_read_depth [rwl_pkg::THREADS_DEF];

    reader_writer_lock_unit_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_thread_id   (i_thread_id),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_readers_now (o_readers_now),
        .o_writer_held (o_writer_held)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one request to the predicted lock state and returns the answer it gets.
    function automatic t_lock_answer resolve_request(t_lock_req r);
        rwl_pkg::t_status st;
        logic             own;
        int               t;
        t_lock_answer     a;
        t = int'(r.tid);
        own = lk_owner_valid && (lk_owner_tid == r.tid);
        case (r.func)
            rwl_pkg::FUNC_WR_LOCK: begin
                if (own) begin
                    if (lk_checks && lk_read_depth[t] != '0) begin
                        st = rwl_pkg::ST_READ_TO_WRITE;
                    end else if (lk_write_depth == '1) begin
                        st = rwl_pkg::ST_OVERFLOW;
                    end else begin
                        lk_write_depth++;
                        st = rwl_pkg::ST_GRANTED;
                    end
                end else if (!lk_owner_valid && lk_reader_count == '0) begin
                    lk_owner_valid = 1'b1;
                    lk_owner_tid = r.tid;
                    lk_write_depth = rwl_pkg::COUNT_W'(1);
                    lk_writers_waiting[t] = 1'b0;
                    st = rwl_pkg::ST_GRANTED;
                end else begin
                    lk_writers_waiting[t] = 1'b1;
                    st = rwl_pkg::ST_WAIT;
                end
            end
            rwl_pkg::FUNC_WR_UNLOCK: begin
                if (!own) begin
                    st = rwl_pkg::ST_INVALID_UNLOCK;
                end else if (lk_write_depth == '0) begin
                    st = rwl_pkg::ST_WRITE_UNDERFLOW;
                end else begin
                    lk_write_depth--;
                    if (lk_write_depth == '0) begin
                        lk_owner_valid = 1'b0;
                        lk_owner_tid = '0;
                    end
                    st = rwl_pkg::ST_GRANTED;
                end
            end
            rwl_pkg::FUNC_RD_LOCK: begin
                if (own) begin
                    // The owning writer reads without counting as a reader.
                    if (lk_checks && lk_read_depth[t] == '1) begin
                        st = rwl_pkg::ST_OVERFLOW;
                    end else begin
                        if (lk_checks) lk_read_depth[t]++;
                        st = rwl_pkg::ST_GRANTED;
                    end
                end else if (lk_writers_waiting != '0 || lk_owner_valid) begin
                    st = rwl_pkg::ST_WAIT;
                end else if (lk_reader_count == '1) begin
                    st = rwl_pkg::ST_OVERFLOW;
                end else if (lk_checks && lk_read_depth[t] == '1) begin
                    st = rwl_pkg::ST_OVERFLOW;
                end else begin
                    lk_reader_count++;
                    if (lk_checks) lk_read_depth[t]++;
                    st = rwl_pkg::ST_GRANTED;
                end
            end
            default: begin
                // Read unlock.
                if (lk_checks && lk_read_depth[t] == '0) begin
                    st = rwl_pkg::ST_READ_DEPTH_UNDERFLOW;
                end else if (!own && (lk_owner_valid || lk_reader_count == '0)) begin
                    st = rwl_pkg::ST_READER_UNDERFLOW;
                end else begin
                    if (!own) lk_reader_count--;
                    if (lk_checks) lk_read_depth[t]--;
                    st = rwl_pkg::ST_GRANTED;
                end
            end
        endcase
        a.status = st;
        a.readers = lk_reader_count;
        a.held = lk_owner_valid;
        return a;
    endfunction

    // Finds a thread with a raised pending bit, or one holding read depth; -1 if none.
    function automatic int find_thread(bit waiter);
        int s;
        int k;
        int t;
        s = $urandom_range(rwl_pkg::THREADS_DEF - 1);
        for (k = 0; k < rwl_pkg::THREADS_DEF; k++) begin
            t = (s + k) % rwl_pkg::THREADS_DEF;
            if (waiter ? lk_writers_waiting[t] : (lk_read_depth[t] != '0)) return t;
        end
        return -1;
    endfunction

    // Mostly requests that make sense for the current lock state, with some noise.
    function automatic t_lock_req pick_request();
        t_lock_req r;
        int        roll;
        int        t;
        roll = $urandom_range(99);
        r.func = rwl_pkg::t_func'($urandom_range(3));
        r.tid = rwl_pkg::TID_W'($urandom_range(rwl_pkg::THREADS_DEF - 1));
        if (roll < 15) return r;
        if (lk_owner_valid) begin
            if (roll < 45) begin
                r.func = rwl_pkg::FUNC_WR_UNLOCK;
            end else if (roll < 55) begin
                r.func = rwl_pkg::FUNC_WR_LOCK;
            end else if (roll < 65) begin
                r.func = rwl_pkg::FUNC_RD_LOCK;
            end else if (roll < 72) begin
                r.func = rwl_pkg::FUNC_RD_UNLOCK;
            end else begin
                // Another writer arrives while the lock is held.
                r.func = rwl_pkg::FUNC_WR_LOCK;
                return r;
            end
            r.tid = lk_owner_tid;
        end else if (lk_reader_count != '0 &&
                     (roll < 50 || (lk_writers_waiting != '0 && roll < 75))) begin
            r.func = rwl_pkg::FUNC_RD_UNLOCK;
            t = find_thread(1'b0);
            if (lk_checks && t >= 0) r.tid = rwl_pkg::TID_W'(t);
        end else if (lk_writers_waiting != '0 && lk_reader_count == '0 && roll < 70) begin
            r.func = rwl_pkg::FUNC_WR_LOCK;
            r.tid = rwl_pkg::TID_W'(find_thread(1'b1));
        end else if (roll < 85) begin
            r.func = rwl_pkg::FUNC_RD_LOCK;
        end else begin
            r.func = rwl_pkg::FUNC_WR_LOCK;
        end
        return r;
    endfunction

    task automatic push_req(rwl_pkg::t_func f, int t);
        t_lock_req r;
        r.func = f;
        r.tid = rwl_pkg::TID_W'(t);
        pending_requests.push_back(r);
    endtask

    task automatic wait_sent();
        while (pending_requests.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    task automatic wait_quiet();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_requests.size() != 0 || expected_answers.size() != 0);
        repeat (4) @(posedge i_clk);
        #1;
    endtask

    task automatic write_checks(bit v);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        #1;
    endtask

    // Releases every holder and lets pending writers through, so a phase starts unlocked.
    task automatic drain_lock();
        int t;
        int guard;
        for (guard = 0; guard < 2000; guard++) begin
            wait_sent();
            if (lk_owner_valid) begin
                push_req(rwl_pkg::FUNC_WR_UNLOCK, int'(lk_owner_tid));
            end else if (lk_reader_count != '0) begin
                t = find_thread(1'b0);
                if (t >= 0) push_req(rwl_pkg::FUNC_RD_UNLOCK, t);
                else if (!lk_checks) push_req(rwl_pkg::FUNC_RD_UNLOCK,
                                              $urandom_range(rwl_pkg::THREADS_DEF - 1));
                else break;
            end else if (lk_writers_waiting != '0) begin
                push_req(rwl_pkg::FUNC_WR_LOCK, find_thread(1'b1));
            end else begin
                break;
            end
        end
        wait_quiet();
    endtask

    task automatic run_random(int n, int pct);
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            wait_sent();
            // Now and then hold the next request until every answer is back.
            if ($urandom_range(99) < 3) begin
                while (expected_answers.size() != 0) begin
                    @(posedge i_clk);
                    #1;
                end
            end
            pending_requests.push_back(pick_request());
        end
    endtask

    // Driver: presents the oldest pending request and holds it until it is taken.
    always @(negedge i_clk) begin
        if (!(start && !took)) begin
            if (i_rst_n && pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_func <= pending_requests[0].func;
                i_thread_id <= pending_requests[0].tid;
            end else begin
                start <= 1'b0;
                i_func <= rwl_pkg::FUNC_W'($urandom_range(3));
                i_thread_id <= rwl_pkg::TID_W'($urandom_range(rwl_pkg::THREADS_DEF - 1));
            end
        end
    end

    // Monitor: predicts each accepted request and checks each answer against the oldest one.
    always @(posedge i_clk) begin : monitor
        t_lock_req    req;
        t_lock_answer want;
        int           k;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (!i_rst_n) begin
            took = 1'b0;
            lk_checks = 1'b1;
            lk_owner_valid = 1'b0;
            lk_owner_tid = '0;
            lk_write_depth = '0;
            lk_reader_count = '0;
            lk_writers_waiting = '0;
            for (k = 0; k < rwl_pkg::THREADS_DEF; k++) lk_read_depth[k] = '0;
        end else begin
            if (i_cfg_we) lk_checks = i_cfg_wdata;
            took = start && !busy;
            if (took) begin
                req = pending_requests.pop_front();
                expected_answers.push_back(resolve_request(req));
            end
            if (o_valid) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: answer with no request outstanding, status %0d",
                             $time, o_status);
                    errors++;
                end else begin
                    want = expected_answers.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_status);
                        errors++;
                    end
                    if (o_readers_now !== want.readers) begin
                        $display("%0t: readers_now expected %0d, got %0d",
                                 $time, want.readers, o_readers_now);
                        errors++;
                    end
                    if (o_writer_held !== want.held) begin
                        $display("%0t: writer_held expected %0d, got %0d",
                                 $time, want.held, o_writer_held);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // Directed requests with checks on.
        write_checks(1'b1);
        push_req(rwl_pkg::FUNC_WR_UNLOCK, 0);   // unlock with no owner
        push_req(rwl_pkg::FUNC_RD_UNLOCK, 0);   // read unlock with no read depth
        push_req(rwl_pkg::FUNC_RD_LOCK, 5);
        push_req(rwl_pkg::FUNC_RD_LOCK, 5);
        push_req(rwl_pkg::FUNC_WR_LOCK, 9);     // refused, raises the pending bit
        push_req(rwl_pkg::FUNC_RD_LOCK, 3);     // a pending writer makes new readers wait
        push_req(rwl_pkg::FUNC_WR_UNLOCK, 5);
        push_req(rwl_pkg::FUNC_RD_UNLOCK, 5);
        push_req(rwl_pkg::FUNC_RD_UNLOCK, 5);
        push_req(rwl_pkg::FUNC_RD_UNLOCK, 5);
        push_req(rwl_pkg::FUNC_WR_LOCK, 9);
        push_req(rwl_pkg::FUNC_WR_LOCK, 9);     // recursive write lock
        push_req(rwl_pkg::FUNC_RD_LOCK, 9);     // owner reads without counting as a reader
        push_req(rwl_pkg::FUNC_WR_LOCK, 9);     // read-to-write while holding read depth
        push_req(rwl_pkg::FUNC_RD_LOCK, 15);
        push_req(rwl_pkg::FUNC_RD_UNLOCK, 9);
        push_req(rwl_pkg::FUNC_RD_UNLOCK, 2);
        push_req(rwl_pkg::FUNC_WR_UNLOCK, 9);
        push_req(rwl_pkg::FUNC_WR_UNLOCK, 9);
        push_req(rwl_pkg::FUNC_RD_LOCK, 15);

        // With checks off, read unlocks from any thread hit the reader count.
        write_checks(1'b0);
        push_req(rwl_pkg::FUNC_RD_UNLOCK, 7);
        push_req(rwl_pkg::FUNC_RD_UNLOCK, 7);   // no readers left
        push_req(rwl_pkg::FUNC_WR_LOCK, 0);
        push_req(rwl_pkg::FUNC_RD_UNLOCK, 7);   // a writer holds the lock
        push_req(rwl_pkg::FUNC_WR_UNLOCK, 0);

        // Counter-full cases: read depth as reader and read depth as owner.
        write_checks(1'b1);
        for (int k = 0; k < 256; k++) push_req(rwl_pkg::FUNC_RD_LOCK, 1);
        for (int k = 0; k < 256; k++) push_req(rwl_pkg::FUNC_RD_UNLOCK, 1);
        push_req(rwl_pkg::FUNC_WR_LOCK, 3);
        for (int k = 0; k < 256; k++) push_req(rwl_pkg::FUNC_RD_LOCK, 3);
        for (int k = 0; k < 255; k++) push_req(rwl_pkg::FUNC_RD_UNLOCK, 3);
        wait_quiet();

        drain_lock();
        write_checks(1'b1);
        run_random(RANDOM_PER_PHASE, 0);
        drain_lock();
        write_checks(1'b0);
        run_random(RANDOM_PER_PHASE, 58);
        drain_lock();
        write_checks(1'b1);
        run_random(RANDOM_PER_PHASE, 25);
        drain_lock();
        write_checks(1'b0);
        run_random(RANDOM_PER_PHASE, 0);
        drain_lock();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rwl_pkg.sv
hw/rtl/rwl_ctrl.sv
hw/rtl/rwl_datapath.sv
hw/rtl/reader_writer_lock_unit_core.sv
hw/rtl/rwl_checker.sv
tb/reader_writer_lock_unit_core_test.sv
